// File: rtl/core/mcop_pkg.sv
// Shared types, constants and register indexes for the Monte Carlo option pricer.
// Used by mcop_front, mcop_core and mc_european_option_pricer_top; no dependencies.
package mcop_pkg;

   // path counter width
   localparam int COUNT_BITS = 32;

   // input queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // configuration register indexes
   localparam logic [2:0] CSR_SPOT   = 3'd0;
   localparam logic [2:0] CSR_STRIKE = 3'd1;
   localparam logic [2:0] CSR_RATE   = 3'd2;
   localparam logic [2:0] CSR_VOL    = 3'd3;
   localparam logic [2:0] CSR_MAT    = 3'd4;
   localparam logic [2:0] CSR_KIND   = 3'd5;

   // fixed-point constants of the exponential unit
   localparam logic [27:0] LN2_Q28 = 28'd186065279;
   localparam logic [28:0] ONE_Q28 = 29'd268435456;
   localparam logic signed [46:0] XCAP = 47'sd6442450944;          // 24.0 in Q.28
   localparam logic signed [46:0] XOFF = 47'sd35 * 47'sd186065279; // 35 * ln2
   localparam logic [6:0] K_BIAS = 7'd63;                          // shift = K_BIAS - q
   // floor(2^40 / LN2_Q28) for the quotient estimate
   localparam logic [12:0] RECIP_LN2 = 13'((64'd1 << 40) / 64'd186065279);

   // ceil(2^33 / n), exact floor division of Taylor terms below 2^29
   localparam logic [34:0] TWO33 = 35'd1 << 33;
   localparam logic [33:0] RECIP_TBL [16] = '{
      34'd0,
      34'((TWO33 + 35'd0) / 35'd1),
      34'((TWO33 + 35'd1) / 35'd2),
      34'((TWO33 + 35'd2) / 35'd3),
      34'((TWO33 + 35'd3) / 35'd4),
      34'((TWO33 + 35'd4) / 35'd5),
      34'((TWO33 + 35'd5) / 35'd6),
      34'((TWO33 + 35'd6) / 35'd7),
      34'((TWO33 + 35'd7) / 35'd8),
      34'((TWO33 + 35'd8) / 35'd9),
      34'((TWO33 + 35'd9) / 35'd10),
      34'((TWO33 + 35'd10) / 35'd11),
      34'((TWO33 + 35'd11) / 35'd12),
      34'd0, 34'd0, 34'd0
   };
   localparam logic [3:0] TAYLOR_LAST = 4'd12;

   typedef struct packed {
      logic [31:0] spot_price;
      logic [31:0] strike_price;
      logic [31:0] risk_free_rate;
      logic [31:0] volatility;
      logic [31:0] maturity;
      logic        option_kind;
   } cfg_type;

   typedef struct packed {
      logic [31:0] normal_sample;
      logic        last_path;
   } q_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HV,
      ST_T1,
      ST_SQRT,
      ST_VS,
      ST_T2,
      ST_EXP_K,
      ST_EXP_F,
      ST_TAY_A,
      ST_TAY_B,
      ST_SCALE,
      ST_PAY,
      ST_DIV,
      ST_DISC,
      ST_OUT
   } state_type;

endpackage

// File: rtl/core/mcop_front.sv
// Front end of the pricer: takes request items and holds them in a short queue.
// Depends on mcop_pkg.
module mcop_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_normal_sample,
   input  logic                  req_last_path,
   output logic                  item_valid,
   output mcop_pkg::q_item_type  item,
   input  logic                  item_pop
);

   mcop_pkg::q_item_type        mem [mcop_pkg::QDEPTH];
   logic [mcop_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mcop_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mcop_pkg::QPTR_W:0]   count_ff, count_in;
   logic                        push, pop;

   assign req_stall  = (count_ff == (mcop_pkg::QPTR_W+1)'(mcop_pkg::QDEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = mem[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= '{normal_sample: req_normal_sample, last_path: req_last_path};
      end
   end

endmodule

// File: rtl/core/mcop_core.sv
// Back end of the pricer: per-path GBM price, payoff accumulation and final estimate.
// Sequencer over shared exponential, square root and divider steps; depends on mcop_pkg.
module mcop_core (
   input  logic                 clock,
   input  logic                 reset,
   input  mcop_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  mcop_pkg::q_item_type item,
   output logic                 item_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_price_estimate
);

   localparam int CW = mcop_pkg::COUNT_BITS;

   mcop_pkg::state_type state_ff, state_in;

   logic [31:0]        z_ff;
   logic               last_ff;
   logic [36:0]        drift_ff;
   logic [43:0]        t1_ff;
   logic [63:0]        sqv_ff, sqr_ff, sqb_ff;
   logic [31:0]        vs_ff;
   logic [33:0]        xo_ff;
   logic [6:0]         q_ff;
   logic [27:0]        f_ff;
   logic [28:0]        t_ff;
   logic [27:0]        p_ff;
   logic [29:0]        tsum_ff;
   logic [3:0]         n_ff;
   logic [31:0]        ev_ff;
   logic               fin_ff;
   logic [31:0]        res_ff;
   logic [63:0]        sum_ff;
   logic [CW-1:0]      cnt_ff;
   logic [63:0]        dq_ff;
   logic [CW-1:0]      rem_ff;
   logic [5:0]         dcnt_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_price_ff;

   logic               rsp_load;
   logic               cnt_full;

   // arithmetic
   logic [63:0]  sig_sq;
   logic [36:0]  drift_c;
   logic [36:0]  dmag;
   logic [63:0]  t1_prod;
   logic [63:0]  sq_try;
   logic         sq_ge;
   logic [63:0]  vs_prod;
   logic [31:0]  zmag;
   logic [63:0]  t2_prod;
   logic [46:0]  s1, s2, x_path;
   logic [31:0]  rmag;
   logic [63:0]  dm_prod;
   logic [46:0]  x_disc;
   logic [46:0]  qp;
   logic [34:0]  qm, fr;
   logic [56:0]  pm;
   logic [61:0]  dmul;
   logic [61:0]  prod, shr, shl;
   logic [5:0]   rshift;
   logic [2:0]   lshift;
   logic [31:0]  scaled;
   logic [31:0]  pay;
   logic [64:0]  sum_add;
   logic [63:0]  sum_new;
   logic [CW:0]  rem_sh;
   logic         div_ge;
   logic [31:0]  mean;

   function automatic logic [33:0] exp_offset(input logic signed [46:0] x);
      logic signed [46:0] xc;
      begin
         xc = x;
         if (x > mcop_pkg::XCAP) begin
            xc = mcop_pkg::XCAP;
         end else if (x < -mcop_pkg::XCAP) begin
            xc = -mcop_pkg::XCAP;
         end
         return 34'(xc + mcop_pkg::XOFF);
      end
   endfunction

   assign cnt_full = (cnt_ff == {CW{1'b1}});

   always_comb begin
      sig_sq  = 64'(cfg.volatility) * 64'(cfg.volatility);
      drift_c = {{5{cfg.risk_free_rate[31]}}, cfg.risk_free_rate} - {2'b00, sig_sq[63:29]};
      dmag    = drift_ff[36] ? 37'(-drift_ff) : drift_ff;
      t1_prod = 64'(dmag[35:4]) * 64'(cfg.maturity);

      sq_try  = sqr_ff + sqb_ff;
      sq_ge   = (sqv_ff >= sq_try);

      vs_prod = 64'(cfg.volatility) * 64'(sqr_ff[31:0]);
      zmag    = z_ff[31] ? 32'(-z_ff) : z_ff;
      t2_prod = 64'(vs_ff) * 64'(zmag);
      s1      = drift_ff[36] ? 47'(-47'(t1_ff)) : 47'(t1_ff);
      s2      = z_ff[31] ? 47'(-47'(t2_prod[63:24])) : 47'(t2_prod[63:24]);
      x_path  = s1 + s2;

      rmag    = cfg.risk_free_rate[31] ? 32'(-cfg.risk_free_rate) : cfg.risk_free_rate;
      dm_prod = 64'(rmag) * 64'(cfg.maturity);
      x_disc  = cfg.risk_free_rate[31] ? 47'(dm_prod[63:24]) : 47'(-47'(dm_prod[63:24]));

      qp      = 47'(xo_ff) * 47'(mcop_pkg::RECIP_LN2);
      qm      = 35'(q_ff) * 35'(mcop_pkg::LN2_Q28);
      fr      = 35'(xo_ff) - qm;

      pm      = 57'(t_ff) * 57'(f_ff);
      dmul    = 62'(p_ff) * 62'(mcop_pkg::RECIP_TBL[n_ff]);

      // shift by 28 - k where k = q - 35
      prod    = 62'(ev_ff) * 62'(tsum_ff);
      rshift  = 6'(mcop_pkg::K_BIAS - q_ff);
      lshift  = 3'(q_ff - mcop_pkg::K_BIAS);
      shr     = prod >> rshift;
      shl     = prod << lshift;
      if (q_ff <= mcop_pkg::K_BIAS) begin
         scaled = (shr[61:32] != '0) ? 32'hFFFF_FFFF : shr[31:0];
      end else begin
         scaled = ((prod >> (6'd32 - 6'(lshift))) != '0) ? 32'hFFFF_FFFF : shl[31:0];
      end

      if (cfg.option_kind) begin
         pay = (cfg.strike_price > res_ff) ? cfg.strike_price - res_ff : '0;
      end else begin
         pay = (res_ff > cfg.strike_price) ? res_ff - cfg.strike_price : '0;
      end
      sum_add = 65'(sum_ff) + 65'(pay);
      sum_new = sum_add[64] ? {64{1'b1}} : sum_add[63:0];

      rem_sh  = {rem_ff, dq_ff[63]};
      div_ge  = (rem_sh >= {1'b0, cnt_ff});
      mean    = (dq_ff[63:32] != '0) ? 32'hFFFF_FFFF : dq_ff[31:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcop_pkg::ST_IDLE: begin
            if (item_valid) begin
               if (!cnt_full) begin
                  state_in = mcop_pkg::ST_HV;
               end else if (item.last_path) begin
                  state_in = mcop_pkg::ST_DIV;
               end
            end
         end
         mcop_pkg::ST_HV:    state_in = mcop_pkg::ST_T1;
         mcop_pkg::ST_T1:    state_in = mcop_pkg::ST_SQRT;
         mcop_pkg::ST_SQRT: begin
            if (sqb_ff[0]) begin
               state_in = mcop_pkg::ST_VS;
            end
         end
         mcop_pkg::ST_VS:    state_in = mcop_pkg::ST_T2;
         mcop_pkg::ST_T2:    state_in = mcop_pkg::ST_EXP_K;
         mcop_pkg::ST_EXP_K: state_in = mcop_pkg::ST_EXP_F;
         mcop_pkg::ST_EXP_F: state_in = mcop_pkg::ST_TAY_A;
         mcop_pkg::ST_TAY_A: state_in = mcop_pkg::ST_TAY_B;
         mcop_pkg::ST_TAY_B: begin
            state_in = (n_ff == mcop_pkg::TAYLOR_LAST) ? mcop_pkg::ST_SCALE
                                                       : mcop_pkg::ST_TAY_A;
         end
         mcop_pkg::ST_SCALE: state_in = fin_ff ? mcop_pkg::ST_OUT : mcop_pkg::ST_PAY;
         mcop_pkg::ST_PAY:   state_in = last_ff ? mcop_pkg::ST_DIV : mcop_pkg::ST_IDLE;
         mcop_pkg::ST_DIV: begin
            if (dcnt_ff == '1) begin
               state_in = mcop_pkg::ST_DISC;
            end
         end
         mcop_pkg::ST_DISC:  state_in = mcop_pkg::ST_EXP_K;
         mcop_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = mcop_pkg::ST_IDLE;
            end
         end
         default:            state_in = mcop_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      item_pop = (state_ff == mcop_pkg::ST_IDLE) && item_valid;
      rsp_load = (state_ff == mcop_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcop_pkg::ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == mcop_pkg::ST_PAY) begin
            sum_ff <= sum_new;
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rsp_load) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_price_ff <= res_ff;
      end
      case (state_ff)
         mcop_pkg::ST_IDLE: begin
            z_ff    <= item.normal_sample;
            last_ff <= item.last_path;
            dq_ff   <= sum_ff;
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         mcop_pkg::ST_HV: begin
            drift_ff <= drift_c;
         end
         mcop_pkg::ST_T1: begin
            t1_ff  <= t1_prod[63:20];
            sqv_ff <= {cfg.maturity, 32'd0};
            sqr_ff <= '0;
            sqb_ff <= 64'd1 << 62;
         end
         mcop_pkg::ST_SQRT: begin
            if (sq_ge) begin
               sqv_ff <= sqv_ff - sq_try;
               sqr_ff <= (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
            sqb_ff <= sqb_ff >> 2;
         end
         mcop_pkg::ST_VS: begin
            vs_ff <= vs_prod[63:32];
         end
         mcop_pkg::ST_T2: begin
            xo_ff  <= exp_offset(x_path);
            ev_ff  <= cfg.spot_price;
            fin_ff <= 1'b0;
         end
         mcop_pkg::ST_EXP_K: begin
            q_ff <= qp[46:40];
         end
         mcop_pkg::ST_EXP_F: begin
            // the estimate is at most one short: fix it up
            if (fr >= 35'(mcop_pkg::LN2_Q28)) begin
               f_ff <= 28'(fr - 35'(mcop_pkg::LN2_Q28));
               q_ff <= q_ff + 1'b1;
            end else begin
               f_ff <= fr[27:0];
            end
            t_ff    <= mcop_pkg::ONE_Q28;
            tsum_ff <= 30'(mcop_pkg::ONE_Q28);
            n_ff    <= 4'd1;
         end
         mcop_pkg::ST_TAY_A: begin
            p_ff <= pm[55:28];
         end
         mcop_pkg::ST_TAY_B: begin
            t_ff    <= dmul[61:33];
            tsum_ff <= tsum_ff + 30'(dmul[61:33]);
            n_ff    <= n_ff + 1'b1;
         end
         mcop_pkg::ST_SCALE: begin
            res_ff <= scaled;
         end
         mcop_pkg::ST_PAY: begin
            dq_ff   <= sum_new;
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         mcop_pkg::ST_DIV: begin
            rem_ff  <= div_ge ? CW'(rem_sh - {1'b0, cnt_ff}) : rem_sh[CW-1:0];
            dq_ff   <= {dq_ff[62:0], div_ge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         mcop_pkg::ST_DISC: begin
            ev_ff  <= mean;
            xo_ff  <= exp_offset(x_disc);
            fin_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_price_estimate = rsp_price_ff;

   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (sum_ff == '0) && (cnt_ff == '0))
      else $error("sum or count not cleared after an estimate");

   a_taylor_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcop_pkg::ST_TAY_B) |-> (n_ff >= 4'd1) && (n_ff <= mcop_pkg::TAYLOR_LAST))
      else $error("Taylor term index out of range");

   a_frac_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcop_pkg::ST_TAY_A) |-> (f_ff < mcop_pkg::LN2_Q28))
      else $error("exponent fraction not reduced below ln2");

   a_exp_at_least_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcop_pkg::ST_SCALE) |-> (tsum_ff >= 30'(mcop_pkg::ONE_Q28)))
      else $error("exp of fraction below one");

endmodule

// File: rtl/core/mc_european_option_pricer_top.sv
// Monte Carlo European option pricer: each request item carries one standard-normal
// sample (signed Q4.28) for one path; the item is queued by the front end (four
// entries) and the back end prices the path under geometric Brownian motion and
// adds the call or put payoff to a running 64-bit sum. In the back end a path runs
// setup, a bit-per-step square root of the maturity, range reduction, the
// twelve-term Taylor exponential (two multiplies per term), scaling and
// accumulation. An item flagged last_path then runs a 64-step restoring division
// of sum by path count and the discount exponential before the Q16.16 estimate
// is offered on the rsp_ channel, after which sum and count clear. Once the count
// is full further paths are skipped. The output register lets the next item be
// taken while an estimate waits to be read. Configuration registers (csr_index
// 0..5: spot, strike, rate, volatility, maturity, option kind) must be written
// only while the block is idle; the block itself does not enforce this.
// Depends on mcop_pkg, mcop_front and mcop_core.
module mc_european_option_pricer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_normal_sample,
   input  logic        req_last_path,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_price_estimate,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   mcop_pkg::cfg_type    cfg_ff, cfg_in;
   mcop_pkg::q_item_type item;
   logic                 item_valid;
   logic                 item_pop;

   // decode the configuration write; ignore indexes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mcop_pkg::CSR_SPOT:   cfg_in.spot_price     = csr_wdata;
            mcop_pkg::CSR_STRIKE: cfg_in.strike_price   = csr_wdata;
            mcop_pkg::CSR_RATE:   cfg_in.risk_free_rate = csr_wdata;
            mcop_pkg::CSR_VOL:    cfg_in.volatility     = csr_wdata;
            mcop_pkg::CSR_MAT:    cfg_in.maturity       = csr_wdata;
            mcop_pkg::CSR_KIND:   cfg_in.option_kind    = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // hold the registers; reset to spot 100, strike 100, rate 0.05, vol 0.2, T 1.0, call
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spot_price     <= 32'd6553600;
         cfg_ff.strike_price   <= 32'd6553600;
         cfg_ff.risk_free_rate <= 32'd13421772;
         cfg_ff.volatility     <= 32'd53687091;
         cfg_ff.maturity       <= 32'd16777216;
         cfg_ff.option_kind    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // queue incoming samples
   mcop_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_normal_sample (req_normal_sample),
      .req_last_path     (req_last_path),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   // price paths and produce the estimate
   mcop_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_price_estimate (rsp_price_estimate)
   );

endmodule

// File: verif/mcop_price_checker.sv
`timescale 1ns / 100ps
// Price checker for mc_european_option_pricer_top: mirrors the CSR writes, prices every
// accepted path item while the count is not full, and compares each price estimate with
// the oldest one predicted. Depends on mcop_pkg for the register indexes and count width.
module mcop_price_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_normal_sample,
   input  logic        req_last_path,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_price_estimate,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam longint LN2 = 186065279;
   localparam longint XLIM = longint'(24) <<< 28;
   localparam logic [63:0] CNT_FULL = (64'd1 << mcop_pkg::COUNT_BITS) - 64'd1;

   logic [31:0] spot, strike, rate, vol, mat;
   logic        put_kind;
   logic [63:0] payoff_sum, path_count;
   logic [31:0] est_queue [$];

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // v * exp(x) with x in signed Q.28, saturated to 32 bits
   function automatic logic [31:0] exp_scaled(logic [63:0] v, longint x);
      longint      k, f, sh;
      logic [63:0] t, acc, prod, res;
      if (x > XLIM) x = XLIM;
      if (x < -XLIM) x = -XLIM;
      k = x / LN2;
      if (x % LN2 < 0) k = k - 1;
      f = x - k * LN2;
      t = 64'd1 << 28;
      acc = t;
      for (int n = 1; n <= 12; n++) begin
         t = ((t * 64'(f)) >> 28) / 64'(n);
         acc = acc + t;
      end
      prod = v[31:0] * acc;
      sh = 28 - k;
      if (sh >= 64) res = 0;
      else if (sh >= 0) res = prod >> sh;
      else if (prod > (64'hFFFF_FFFF >> (-sh))) res = 64'hFFFF_FFFF;
      else res = prod << (-sh);
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      return res[31:0];
   endfunction

   function automatic logic [31:0] terminal_price(logic [31:0] z_raw);
      longint      z, r, drift, x;
      logic [63:0] hv, dmag, t1, sq, vs, zmag, t2;
      z = longint'(signed'(z_raw));
      r = longint'(signed'(rate));
      hv = (64'(vol) * 64'(vol)) >> 29;
      drift = r - longint'(hv);
      dmag = drift < 0 ? 64'(-drift) : 64'(drift);
      t1 = ((dmag >> 4) * 64'(mat)) >> 20;
      sq = int_sqrt(64'(mat) << 32);
      vs = (64'(vol) * sq) >> 32;
      zmag = z < 0 ? 64'(-z) : 64'(z);
      t2 = (vs * zmag) >> 24;
      x = (drift < 0 ? -longint'(t1) : longint'(t1)) + (z < 0 ? -longint'(t2) : longint'(t2));
      return exp_scaled(64'(spot), x);
   endfunction

   function automatic logic [31:0] discounted_mean();
      longint      r, disc;
      logic [63:0] rmag, dm, mean;
      if (path_count == 0) return 32'd0;
      r = longint'(signed'(rate));
      rmag = r < 0 ? 64'(-r) : 64'(r);
      dm = (rmag * 64'(mat)) >> 24;
      disc = r < 0 ? longint'(dm) : -longint'(dm);
      mean = payoff_sum / path_count;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      return exp_scaled(mean, disc);
   endfunction

   always @(posedge clock) begin
      logic [31:0] st, want;
      logic [63:0] pay;
      if (reset) begin
         spot <= 32'd6553600;
         strike <= 32'd6553600;
         rate <= 32'd13421772;
         vol <= 32'd53687091;
         mat <= 32'd16777216;
         put_kind <= 1'b0;
         payoff_sum = 0;
         path_count = 0;
         est_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mcop_pkg::CSR_SPOT: spot <= csr_wdata;
               mcop_pkg::CSR_STRIKE: strike <= csr_wdata;
               mcop_pkg::CSR_RATE: rate <= csr_wdata;
               mcop_pkg::CSR_VOL: vol <= csr_wdata;
               mcop_pkg::CSR_MAT: mat <= csr_wdata;
               mcop_pkg::CSR_KIND: put_kind <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (path_count < CNT_FULL) begin
               st = terminal_price(req_normal_sample);
               if (put_kind) pay = strike > st ? 64'(strike - st) : 0;
               else pay = st > strike ? 64'(st - strike) : 0;
               if (payoff_sum > ~pay) payoff_sum = '1;
               else payoff_sum = payoff_sum + pay;
               path_count = path_count + 1;
            end
            if (req_last_path) begin
               est_queue = {est_queue, discounted_mean()};
               payoff_sum = 0;
               path_count = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (est_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected estimate %h", rsp_price_estimate);
               fail_count <= fail_count + 1;
            end else begin
               want = est_queue.pop_front();
               if (want !== rsp_price_estimate) begin
                  if (fail_count < 10)
                     $display("ERROR: price_estimate expected %h actual %h",
                              want, rsp_price_estimate);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= est_queue.size();
      end
   end

endmodule

// File: verif/tb_mc_european_option_pricer_top.sv
`timescale 1ns / 100ps
// Testbench top for mc_european_option_pricer_top: drives CSR settings and path items,
// with random idling on both channels. Depends on mcop_pkg and mcop_price_checker.
module tb_mc_european_option_pricer_top;

   // cycles without any accepted item before the run is called hung
   localparam int WATCHDOG_LIMIT = 10000;
   // margin for four queued paths plus one in flight to finish
   localparam int DRAIN_CYCLES = 500;
   localparam int LONG_HOLD = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_normal_sample = '0;
   logic        req_last_path = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_price_estimate;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int   fail_count, pending;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   always #5 clock = ~clock;

   mc_european_option_pricer_top dut (.*);

   mcop_price_checker checker_i (.*);

   // Receiver: a toggle of hold_toggle starts a long hold-off; otherwise stall at random.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Write all six registers back to back, then drop the enable.
   task automatic load_settings(logic [31:0] s, logic [31:0] k, logic [31:0] r,
                                logic [31:0] v, logic [31:0] m, logic kind);
      logic [31:0] vals [6];
      logic [2:0]  idx [6];
      vals = '{s, k, r, v, m, {31'd0, kind}};
      idx = '{mcop_pkg::CSR_SPOT, mcop_pkg::CSR_STRIKE, mcop_pkg::CSR_RATE,
              mcop_pkg::CSR_VOL, mcop_pkg::CSR_MAT, mcop_pkg::CSR_KIND};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Offer one path item and hold it until accepted; idle before it at random.
   task automatic send_path(logic [31:0] z, logic last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_normal_sample <= z;
      req_last_path <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every estimate, then let queued paths finish.
   task automatic drain();
      req_valid <= 1'b0;
      req_last_path <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_sample();
      if ($urandom_range(0, 99) < 30) return $urandom();
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   // One random estimate: mostly short, some longer runs of paths.
   task automatic send_estimate(output int used);
      int n;
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      for (int i = 0; i < n; i++) send_path(random_sample(), i == n - 1);
      used = n;
   endtask

   initial begin
      int used, sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-like settings, sample extremes, single- and multi-path estimates
      load_settings(32'd6553600, 32'd6553600, 32'd13421772, 32'd53687091, 32'd16777216, 1'b0);
      send_path(32'd0, 1'b1);
      send_path(32'h7FFF_FFFF, 1'b1);
      send_path(32'h8000_0000, 1'b1);
      send_path(32'd1, 1'b0);
      send_path(32'hFFFF_FFFF, 1'b1);
      send_path(32'h3000_0000, 1'b0);
      send_path(32'hD000_0000, 1'b0);
      send_path(32'h1000_0000, 1'b1);
      drain();

      // directed: put with every register at its top; exponent clamps both ways
      load_settings('1, '1, 32'h7FFF_FFFF, '1, '1, 1'b1);
      send_path(32'h7FFF_FFFF, 1'b0);
      send_path(32'h8000_0000, 1'b1);
      drain();
      load_settings('1, 32'd0, 32'h8000_0000, '1, '1, 1'b0);
      send_path(32'h8000_0000, 1'b0);
      send_path(32'h7FFF_FFFF, 1'b1);
      send_path(32'd0, 1'b1);
      drain();

      // directed: everything zero, call then put
      load_settings('0, '0, '0, '0, '0, 1'b0);
      send_path(32'h5555_5555, 1'b0);
      send_path(32'hAAAA_AAAA, 1'b1);
      drain();
      load_settings('0, 32'd6553600, '0, '0, '0, 1'b1);
      send_path(32'd0, 1'b1);
      drain();

      // random phases: idling mode switches after three and six phases
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 50;
         end else if (ph < 6) begin
            send_idle_pct = 50;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 7 || $urandom_range(0, 3) == 0)
            load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          1'($urandom()));
         else
            load_settings($urandom_range(32'h0010_0000, 32'h00C8_0000),
                          $urandom_range(32'h0010_0000, 32'h00C8_0000),
                          $urandom_range(0, 32'd107374182) - 32'd53687091,
                          $urandom_range(0, 32'h1000_0000),
                          $urandom_range(0, 32'h0400_0000), 1'($urandom()));
         // hold the receiver off while the sender keeps offering, so the queue backs up
         if (ph == 6) hold_toggle <= ~hold_toggle;
         sent = 0;
         while (sent < 200) begin
            send_estimate(used);
            sent += used;
            // pause now and then until every estimate is back
            if ($urandom_range(0, 19) == 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/mcop_pkg.sv
rtl/core/mcop_front.sv
rtl/core/mcop_core.sv
rtl/core/mc_european_option_pricer_top.sv
verif/mcop_price_checker.sv
verif/tb_mc_european_option_pricer_top.sv
